### hw/rtl/isbc_pkg.sv
// ----------------------------------------------------------------------------
// isbc_pkg
// Shared types and constants for the imu scale, bias and calibration block.
// ----------------------------------------------------------------------------
package isbc_pkg;

  localparam int unsigned RAW_W      = 16;
  localparam int unsigned ACCEL_W    = 19;
  localparam int unsigned TEMP_W     = 15;
  localparam int unsigned RATE_W     = 20;
  localparam int unsigned ACCUM_W    = 32;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned NUM_LANES  = 3;

  localparam int unsigned MAX_CALIB_SAMPLES = 4096;

  // gyro reciprocals, round(65536 * 128 / sensitivity)
  localparam int unsigned RECIP_W = 19;
  localparam logic [RECIP_W-1:0] RATE_RECIP [4] = '{
    19'd64035, 19'd128070, 19'd255750, 19'd511500
  };

  // temperature: raw * 5 / 17 by a reciprocal, exact for 18-bit numerators
  localparam int unsigned TEMP_NUM_W   = 18;
  localparam int unsigned TEMP_SHIFT   = 22;
  localparam int unsigned TEMP_PROD_W  = 36;
  localparam logic [17:0] TEMP_RECIP   = 18'd246724;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 15'sd3653;

  localparam int unsigned DIV_STEPS = ACCUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef logic [1:0]            cfg_index_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic [1:0] {
    CFG_ACCEL_RANGE = 2'd0,
    CFG_RATE_RANGE  = 2'd1,
    CFG_CALIB_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_CONVERT    = 2'd0,
    ACT_CAL_START  = 2'd1,
    ACT_CAL_SAMPLE = 2'd2,
    ACT_SET_BIAS   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_CONVERTED   = 3'd0,
    ST_CALIBRATING = 3'd1,
    ST_CAL_DONE    = 3'd2,
    ST_BIAS_SET    = 3'd3,
    ST_NOT_STARTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    LCMD_NONE,
    LCMD_SCALE,
    LCMD_CLEAR,
    LCMD_SET_BIAS,
    LCMD_ACCUM,
    LCMD_DIV_START
  } lane_cmd_t;

  typedef struct packed {
    lane_cmd_t  cmd;
    logic [1:0] rate_range;
    count_t     divisor;
  } lane_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

endpackage

### hw/rtl/isbc_if.sv
// ----------------------------------------------------------------------------
// isbc channel interfaces
// Raw sample channel and converted result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface isbc_sample_if;
  logic                    valid;
  logic                    ready;
  isbc_pkg::action_t       action;
  logic signed [15:0]      accel_x_raw;
  logic signed [15:0]      accel_y_raw;
  logic signed [15:0]      accel_z_raw;
  logic signed [15:0]      temp_raw;
  logic signed [15:0]      rate_x_raw;
  logic signed [15:0]      rate_y_raw;
  logic signed [15:0]      rate_z_raw;

  modport source (
    output valid, action, accel_x_raw, accel_y_raw, accel_z_raw, temp_raw,
           rate_x_raw, rate_y_raw, rate_z_raw,
    input  ready
  );
  modport sink (
    input  valid, action, accel_x_raw, accel_y_raw, accel_z_raw, temp_raw,
           rate_x_raw, rate_y_raw, rate_z_raw,
    output ready
  );
endinterface

interface isbc_result_if;
  logic                    valid;
  logic                    ready;
  logic signed [18:0]      accel_x_out;
  logic signed [18:0]      accel_y_out;
  logic signed [18:0]      accel_z_out;
  logic signed [14:0]      temp_centi_c;
  logic signed [19:0]      rate_x_out;
  logic signed [19:0]      rate_y_out;
  logic signed [19:0]      rate_z_out;
  isbc_pkg::status_t       status;

  modport source (
    output valid, accel_x_out, accel_y_out, accel_z_out, temp_centi_c,
           rate_x_out, rate_y_out, rate_z_out, status,
    input  ready
  );
  modport sink (
    input  valid, accel_x_out, accel_y_out, accel_z_out, temp_centi_c,
           rate_x_out, rate_y_out, rate_z_out, status,
    output ready
  );
endinterface

### hw/rtl/isbc_lane.sv
// ----------------------------------------------------------------------------
// isbc_lane
// One gyro axis: rate scaling, bias correction, calibration accumulator and
// bit-serial bias divider.
// ----------------------------------------------------------------------------
module isbc_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  isbc_pkg::lane_ctrl_t    ctrl,
  input  logic signed [15:0]      raw,
  output logic signed [19:0]      rate_out,
  output logic                    div_busy
);
  import isbc_pkg::*;

  logic signed [RATE_W-1:0]  scaled;
  logic signed [RATE_W-1:0]  bias;
  logic signed [ACCUM_W-1:0] accum;

  logic signed [35:0]        prod;
  logic signed [35:0]        prod_rnd;
  logic signed [RATE_W:0]    diff;
  logic signed [ACCUM_W:0]   acc_sum;
  logic signed [ACCUM_W-1:0] acc_sat;

  logic [COUNT_W-1:0]        den;
  logic [COUNT_W-1:0]        rem;
  logic [ACCUM_W-1:0]        quo;
  logic                      neg;
  logic [DIV_CNT_W-1:0]      cnt;
  logic [COUNT_W:0]          shifted;
  logic [COUNT_W:0]          trial;
  logic                      ge;
  logic signed [ACCUM_W:0]   q_signed;
  logic signed [RATE_W-1:0]  q_sat;
  logic [ACCUM_W-1:0]        accum_mag;

  // scaled rate, round half up
  assign prod     = raw * $signed({1'b0, RATE_RECIP[ctrl.rate_range]});
  assign prod_rnd = prod + 36'sd32768;

  // bias correction with saturation
  assign diff = {scaled[RATE_W-1], scaled} - {bias[RATE_W-1], bias};
  always_comb begin
    if (diff > $signed(21'sd524287)) begin
      rate_out = 20'sd524287;
    end else if (diff < $signed(-21'sd524288)) begin
      rate_out = -20'sd524288;
    end else begin
      rate_out = diff[RATE_W-1:0];
    end
  end

  // accumulator with 32-bit saturation
  assign acc_sum = {accum[ACCUM_W-1], accum}
                 + {{(ACCUM_W-RATE_W+1){scaled[RATE_W-1]}}, scaled};
  always_comb begin
    if (acc_sum[ACCUM_W] != acc_sum[ACCUM_W-1]) begin
      acc_sat = acc_sum[ACCUM_W] ? {1'b1, {(ACCUM_W-1){1'b0}}}
                                 : {1'b0, {(ACCUM_W-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[ACCUM_W-1:0];
    end
  end

  // restoring divider step
  assign accum_mag = accum[ACCUM_W-1] ? (~accum + 1'b1) : accum;
  assign shifted   = {rem, quo[ACCUM_W-1]};
  assign ge        = shifted >= {1'b0, den};
  assign trial     = shifted - {1'b0, den};

  assign q_signed = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
  always_comb begin
    if (q_signed > $signed(33'sd524287)) begin
      q_sat = 20'sd524287;
    end else if (q_signed < $signed(-33'sd524288)) begin
      q_sat = -20'sd524288;
    end else begin
      q_sat = q_signed[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cmd == LCMD_SCALE) begin
      scaled <= prod_rnd[35:16];
    end
    if (ctrl.cmd == LCMD_DIV_START) begin
      den <= ctrl.divisor;
      rem <= '0;
      quo <= accum_mag;
      neg <= accum[ACCUM_W-1];
    end else if (div_busy && cnt != '0) begin
      rem <= ge ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
      quo <= {quo[ACCUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias     <= '0;
      accum    <= '0;
      div_busy <= 1'b0;
      cnt      <= '0;
    end else begin
      unique case (ctrl.cmd)
        LCMD_CLEAR: begin
          bias  <= '0;
          accum <= '0;
        end
        LCMD_SET_BIAS: begin
          bias <= {{(RATE_W-RAW_W){raw[RAW_W-1]}}, raw};
        end
        LCMD_ACCUM: begin
          accum <= acc_sat;
        end
        LCMD_DIV_START: begin
          div_busy <= 1'b1;
          cnt      <= DIV_CNT_W'(DIV_STEPS);
        end
        default: begin
        end
      endcase
      if (div_busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          bias     <= q_sat;
          div_busy <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/imu_scale_bias_calibrate_top.sv
// ----------------------------------------------------------------------------
// imu_scale_bias_calibrate_top
// Flow: an accepted item passes S_MUL, S_ACT and S_DONE, then its result is
// registered; a calibration sample that closes the run also passes S_DIV_GO and
// S_DIV_WAIT (32-step bias divider per gyro lane). One item at a time; the next
// item is taken while the previous result waits on the output register.
// Reset: synchronous; ranges 1, calib_count 200, bias/accumulators cleared.
// ----------------------------------------------------------------------------
module imu_scale_bias_calibrate_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  isbc_pkg::cfg_index_t  wr_index,
  input  isbc_pkg::cfg_data_t   wr_data,
  isbc_sample_if.sink           sample,
  isbc_result_if.source         result
);
  import isbc_pkg::*;

  state_t state, state_next;

  logic [1:0]  accel_range;
  logic [1:0]  rate_range;
  count_t      calib_count;
  count_t      cal_seen;
  logic        calibrating;
  count_t      div_den;
  status_t     status_q;

  // captured item
  action_t            action_q;
  logic signed [15:0] accel_q [3];
  logic signed [15:0] temp_q;
  logic signed [15:0] rate_q [NUM_LANES];

  logic [TEMP_PROD_W-1:0] temp_prod;
  logic [15:0]            temp_mag;
  logic [TEMP_NUM_W-1:0]  temp_num;
  logic [13:0]            temp_quo;
  logic signed [TEMP_W-1:0] temp_val;

  lane_ctrl_t          lane_ctrl;
  logic signed [19:0]  lane_rate [NUM_LANES];
  logic [NUM_LANES-1:0] lane_busy;

  count_t  eff_count;
  count_t  seen_next;
  logic    cal_finish;
  logic    accept;
  logic    load_out;

  function automatic logic signed [ACCEL_W-1:0] accel_scale(
    input logic signed [15:0] raw, input logic [1:0] range);
    logic signed [ACCEL_W-1:0] ext;
    ext = {{(ACCEL_W-RAW_W){raw[RAW_W-1]}}, raw};
    return ext <<< range;
  endfunction

  assign accept       = sample.valid && sample.ready;
  assign sample.ready = !rst && (state == S_IDLE);
  assign load_out     = (state == S_DONE) && (!result.valid || result.ready);

  // effective calibration length
  always_comb begin
    if (calib_count == '0) begin
      eff_count = count_t'(1);
    end else if (calib_count > count_t'(MAX_CALIB_SAMPLES)) begin
      eff_count = count_t'(MAX_CALIB_SAMPLES);
    end else begin
      eff_count = calib_count;
    end
  end
  assign seen_next  = cal_seen + 1'b1;
  assign cal_finish = (seen_next >= eff_count) || (seen_next == '0);

  // temperature: |t| * 5 / 17
  assign temp_mag = temp_q[15] ? 16'(-temp_q) : temp_q;
  assign temp_num = {2'b00, temp_mag} + {temp_mag, 2'b00};
  assign temp_quo = temp_prod[TEMP_PROD_W-1:TEMP_SHIFT];
  assign temp_val = (temp_q[15] ? -$signed({1'b0, temp_quo}) : $signed({1'b0, temp_quo}))
                  + TEMP_OFFSET;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_range <= 2'd1;
      rate_range  <= 2'd1;
      calib_count <= count_t'(200);
    end else if (wr_en) begin
      case (wr_index)
        CFG_ACCEL_RANGE: accel_range <= wr_data[1:0];
        CFG_RATE_RANGE:  rate_range  <= wr_data[1:0];
        CFG_CALIB_COUNT: calib_count <= wr_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // item capture and temperature product
  always_ff @(posedge clk) begin
    if (accept) begin
      action_q   <= sample.action;
      accel_q[0] <= sample.accel_x_raw;
      accel_q[1] <= sample.accel_y_raw;
      accel_q[2] <= sample.accel_z_raw;
      temp_q     <= sample.temp_raw;
      rate_q[0]  <= sample.rate_x_raw;
      rate_q[1]  <= sample.rate_y_raw;
      rate_q[2]  <= sample.rate_z_raw;
    end
    if (state == S_MUL) begin
      temp_prod <= temp_num * TEMP_RECIP;
    end
  end

  // gyro lanes
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    isbc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl),
      .raw      (rate_q[i]),
      .rate_out (lane_rate[i]),
      .div_busy (lane_busy[i])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next           = state;
    lane_ctrl.cmd        = LCMD_NONE;
    lane_ctrl.rate_range = rate_range;
    lane_ctrl.divisor    = div_den;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        lane_ctrl.cmd = LCMD_SCALE;
        state_next    = S_ACT;
      end
      S_ACT: begin
        state_next = S_DONE;
        case (action_q)
          ACT_CAL_START: lane_ctrl.cmd = LCMD_CLEAR;
          ACT_SET_BIAS:  lane_ctrl.cmd = LCMD_SET_BIAS;
          ACT_CAL_SAMPLE: begin
            if (calibrating) begin
              lane_ctrl.cmd = LCMD_ACCUM;
              if (cal_finish) begin
                state_next = S_DIV_GO;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_DIV_GO: begin
        lane_ctrl.cmd = LCMD_DIV_START;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (lane_busy == '0) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // calibration control
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_seen    <= '0;
      calibrating <= 1'b0;
      div_den     <= count_t'(1);
      status_q    <= ST_CONVERTED;
    end else if (state == S_ACT) begin
      case (action_q)
        ACT_CONVERT: status_q <= ST_CONVERTED;
        ACT_CAL_START: begin
          cal_seen    <= '0;
          calibrating <= 1'b1;
          status_q    <= ST_CALIBRATING;
        end
        ACT_CAL_SAMPLE: begin
          if (!calibrating) begin
            status_q <= ST_NOT_STARTED;
          end else begin
            cal_seen <= seen_next;
            div_den  <= (seen_next == '0) ? count_t'(1) : seen_next;
            if (cal_finish) begin
              calibrating <= 1'b0;
              status_q    <= ST_CAL_DONE;
            end else begin
              status_q <= ST_CALIBRATING;
            end
          end
        end
        default: status_q <= ST_BIAS_SET;
      endcase
    end
  end

  // result register, merges the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.status <= status_q;
      if (action_q == ACT_CONVERT) begin
        result.accel_x_out  <= accel_scale(accel_q[0], accel_range);
        result.accel_y_out  <= accel_scale(accel_q[1], accel_range);
        result.accel_z_out  <= accel_scale(accel_q[2], accel_range);
        result.temp_centi_c <= temp_val;
        result.rate_x_out   <= lane_rate[0];
        result.rate_y_out   <= lane_rate[1];
        result.rate_z_out   <= lane_rate[2];
      end else begin
        result.accel_x_out  <= '0;
        result.accel_y_out  <= '0;
        result.accel_z_out  <= '0;
        result.temp_centi_c <= '0;
        result.rate_x_out   <= '0;
        result.rate_y_out   <= '0;
        result.rate_z_out   <= '0;
      end
    end
  end

endmodule

### tb/imu_scale_bias_calibrate_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_scale_bias_calibrate_top_tb
// Drives raw IMU samples, calibration runs and bias loads through the
// imu_scale_bias_calibrate_top channels under every range setting and many count settings.
// A scoreboard class computes the expected physical values from its own copy
// of the ranges, bias and accumulators, and checks every result in order.
// ----------------------------------------------------------------------------
module imu_scale_bias_calibrate_top_tb;
  import isbc_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RST_CYCLES   = 9;
  localparam int DRAIN_CYCLES = 40;
  localparam int RAND_PHASES  = 12;
  localparam int QUIET_PHASES = 2;
  localparam int PHASE_ITEMS  = 140;
  localparam int LONG_RUN     = 40;

  localparam longint GYRO_RECIP [4] = '{64035, 128070, 255750, 511500};
  localparam longint RATE_MIN  = -524288;
  localparam longint RATE_MAX  = 524287;
  localparam longint ACCUM_MIN = -64'sd2147483648;
  localparam longint ACCUM_MAX = 2147483647;

  typedef struct {
    action_t            action;
    logic signed [15:0] accel [NUM_LANES];
    logic signed [15:0] temp;
    logic signed [15:0] rate [NUM_LANES];
  } raw_sample_t;

  typedef struct {
    logic signed [18:0] accel [NUM_LANES];
    logic signed [14:0] temp;
    logic signed [19:0] rate [NUM_LANES];
    status_t            status;
  } phys_result_t;

  class imu_phys_board;
    logic [1:0]         accel_rng;
    logic [1:0]         gyro_rng;
    logic [12:0]        avg_len;
    logic signed [19:0] bias [NUM_LANES];
    logic signed [31:0] accum [NUM_LANES];
    logic [12:0]        cal_seen;
    bit                 averaging;
    phys_result_t       pending [$];
    int                 mismatches;

    function new();
      accel_rng  = 2'd1;
      gyro_rng   = 2'd1;
      avg_len    = 13'd200;
      cal_seen   = '0;
      averaging  = 1'b0;
      mismatches = 0;
      for (int i = 0; i < NUM_LANES; i++) begin
        bias[i]  = '0;
        accum[i] = '0;
      end
    endfunction

    function void write_reg(cfg_reg_t idx, cfg_data_t d);
      case (idx)
        CFG_ACCEL_RANGE: accel_rng = d[1:0];
        CFG_RATE_RANGE:  gyro_rng  = d[1:0];
        CFG_CALIB_COUNT: avg_len   = d[12:0];
        default: ;
      endcase
    endfunction

    // round half up of raw * recip / 65536
    function longint gyro_scaled(logic signed [15:0] raw);
      return (longint'(raw) * GYRO_RECIP[gyro_rng] + 64'sd32768) >>> 16;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function void note_input(raw_sample_t s);
      phys_result_t r;
      logic [12:0]  n;
      logic [12:0]  d;
      r.temp   = '0;
      r.status = ST_CONVERTED;
      for (int i = 0; i < NUM_LANES; i++) begin
        r.accel[i] = '0;
        r.rate[i]  = '0;
      end
      case (s.action)
        ACT_CONVERT: begin
          for (int i = 0; i < NUM_LANES; i++) begin
            r.accel[i] = 19'(longint'(s.accel[i]) <<< accel_rng);
            r.rate[i]  = 20'(clamp(gyro_scaled(s.rate[i]) - bias[i], RATE_MIN, RATE_MAX));
          end
          r.temp = 15'((int'(s.temp) * 100) / 340 + 3653);
        end
        ACT_CAL_START: begin
          for (int i = 0; i < NUM_LANES; i++) begin
            bias[i]  = '0;
            accum[i] = '0;
          end
          cal_seen  = '0;
          averaging = 1'b1;
          r.status  = ST_CALIBRATING;
        end
        ACT_CAL_SAMPLE: begin
          if (!averaging) begin
            r.status = ST_NOT_STARTED;
          end else begin
            n = (avg_len == 0) ? 13'd1 :
                ((avg_len > MAX_CALIB_SAMPLES) ? 13'(MAX_CALIB_SAMPLES) : avg_len);
            for (int i = 0; i < NUM_LANES; i++)
              accum[i] = 32'(clamp(longint'(accum[i]) + gyro_scaled(s.rate[i]),
                                   ACCUM_MIN, ACCUM_MAX));
            cal_seen = cal_seen + 13'd1;
            if (cal_seen >= n || cal_seen == 0) begin
              d = (cal_seen == 0) ? 13'd1 : cal_seen;
              for (int i = 0; i < NUM_LANES; i++)
                bias[i] = 20'(clamp(longint'(accum[i]) / longint'(d), RATE_MIN, RATE_MAX));
              averaging = 1'b0;
              r.status  = ST_CAL_DONE;
            end else begin
              r.status = ST_CALIBRATING;
            end
          end
        end
        default: begin
          for (int i = 0; i < NUM_LANES; i++)
            bias[i] = s.rate[i];
          r.status = ST_BIAS_SET;
        end
      endcase
      pending.push_back(r);
    endfunction

    function string show(phys_result_t r);
      return $sformatf("accel %0d %0d %0d temp %0d rate %0d %0d %0d status %0d",
                       r.accel[0], r.accel[1], r.accel[2], r.temp,
                       r.rate[0], r.rate[1], r.rate[2], r.status);
    endfunction

    function void check_result(phys_result_t got);
      phys_result_t want;
      bit           bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no item pending: %s", $time, show(got));
        return;
      end
      want = pending.pop_front();
      bad  = (got.temp !== want.temp) || (got.status !== want.status);
      for (int i = 0; i < NUM_LANES; i++)
        bad |= (got.accel[i] !== want.accel[i]) || (got.rate[i] !== want.rate[i]);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         wr_en;
  cfg_index_t   wr_index;
  cfg_data_t    wr_data;

  isbc_sample_if sample_ch ();
  isbc_result_if result_ch ();

  imu_phys_board board;
  bit            idle_on;
  int unsigned   items_sent;

  imu_scale_bias_calibrate_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sample   (sample_ch),
    .result   (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("imu_scale_bias_calibrate_top_tb: done, errors");
    $finish;
  end

  // result side stalls
  initial begin
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    raw_sample_t  seen_in;
    phys_result_t seen_out;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      seen_in.action   = sample_ch.action;
      seen_in.accel[0] = sample_ch.accel_x_raw;
      seen_in.accel[1] = sample_ch.accel_y_raw;
      seen_in.accel[2] = sample_ch.accel_z_raw;
      seen_in.temp     = sample_ch.temp_raw;
      seen_in.rate[0]  = sample_ch.rate_x_raw;
      seen_in.rate[1]  = sample_ch.rate_y_raw;
      seen_in.rate[2]  = sample_ch.rate_z_raw;
      board.note_input(seen_in);
    end
    if (!rst && result_ch.valid && result_ch.ready) begin
      seen_out.accel[0] = result_ch.accel_x_out;
      seen_out.accel[1] = result_ch.accel_y_out;
      seen_out.accel[2] = result_ch.accel_z_out;
      seen_out.temp     = result_ch.temp_centi_c;
      seen_out.rate[0]  = result_ch.rate_x_out;
      seen_out.rate[1]  = result_ch.rate_y_out;
      seen_out.rate[2]  = result_ch.rate_z_out;
      seen_out.status   = result_ch.status;
      board.check_result(seen_out);
    end
  end

  function automatic logic signed [15:0] pick_raw();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic raw_sample_t make_sample(action_t a);
    raw_sample_t s;
    s.action = a;
    s.temp   = pick_raw();
    for (int i = 0; i < NUM_LANES; i++) begin
      s.accel[i] = pick_raw();
      s.rate[i]  = pick_raw();
    end
    return s;
  endfunction

  function automatic raw_sample_t flat_sample(action_t a, logic signed [15:0] acc,
                                              logic signed [15:0] tmp,
                                              logic signed [15:0] rt);
    raw_sample_t s;
    s.action = a;
    s.temp   = tmp;
    for (int i = 0; i < NUM_LANES; i++) begin
      s.accel[i] = acc;
      s.rate[i]  = rt;
    end
    return s;
  endfunction

  task automatic push_sample(input raw_sample_t s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    sample_ch.valid       <= 1'b1;
    sample_ch.action      <= s.action;
    sample_ch.accel_x_raw <= s.accel[0];
    sample_ch.accel_y_raw <= s.accel[1];
    sample_ch.accel_z_raw <= s.accel[2];
    sample_ch.temp_raw    <= s.temp;
    sample_ch.rate_x_raw  <= s.rate[0];
    sample_ch.rate_y_raw  <= s.rate[1];
    sample_ch.rate_z_raw  <= s.rate[2];
    do @(posedge clk); while (!sample_ch.ready);
    items_sent++;
  endtask

  // wait until every result is back and the block has gone quiet
  task automatic settle_block();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_reg(input cfg_reg_t idx, input int unsigned val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= cfg_data_t'(val);
    @(posedge clk);
    board.write_reg(idx, cfg_data_t'(val));
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    raw_sample_t item_buf;
    int unsigned count_cfg;
    int unsigned run_len;
    int unsigned phase_end;

    board      = new();
    idle_on    = 1'b1;
    items_sent = 0;
    rst      <= 1'b1;
    wr_en    <= 1'b0;
    wr_index <= CFG_ACCEL_RANGE;
    wr_data  <= '0;
    sample_ch.valid       <= 1'b0;
    sample_ch.action      <= ACT_CONVERT;
    sample_ch.accel_x_raw <= '0;
    sample_ch.accel_y_raw <= '0;
    sample_ch.accel_z_raw <= '0;
    sample_ch.temp_raw    <= '0;
    sample_ch.rate_x_raw  <= '0;
    sample_ch.rate_y_raw  <= '0;
    sample_ch.rate_z_raw  <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset ranges: extremes, idle calibration sample, bias loads
    push_sample(flat_sample(ACT_CONVERT, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    push_sample(flat_sample(ACT_CONVERT, 16'sh8000, 16'sh8000, 16'sh8000));
    push_sample(flat_sample(ACT_CONVERT, 16'sh0000, 16'sh0000, 16'sh0000));
    push_sample(flat_sample(ACT_CONVERT, 16'shffff, 16'sh0001, 16'shffff));
    push_sample(flat_sample(ACT_CAL_SAMPLE, 16'sh0001, 16'sh0001, 16'sh03e8));
    push_sample(flat_sample(ACT_SET_BIAS, 16'sh0000, 16'sh0000, 16'sh8000));
    push_sample(flat_sample(ACT_CONVERT, 16'sh7fff, 16'sh8000, 16'sh7fff));
    push_sample(flat_sample(ACT_SET_BIAS, 16'sh0000, 16'sh0000, 16'sh7fff));
    push_sample(flat_sample(ACT_CONVERT, 16'sh0000, 16'sh0000, 16'sh8000));

    // widest ranges, short calibration
    settle_block();
    load_reg(CFG_ACCEL_RANGE, 3);
    load_reg(CFG_RATE_RANGE, 3);
    load_reg(CFG_CALIB_COUNT, 3);
    push_sample(make_sample(ACT_CAL_START));
    push_sample(flat_sample(ACT_CAL_SAMPLE, 16'sh0000, 16'sh0000, 16'sh7fff));
    push_sample(flat_sample(ACT_CAL_SAMPLE, 16'sh0000, 16'sh0000, 16'sh8000));
    push_sample(flat_sample(ACT_CAL_SAMPLE, 16'sh0000, 16'sh0000, 16'sh7fff));
    push_sample(flat_sample(ACT_CONVERT, 16'sh8000, 16'sh8000, 16'sh8000));

    // narrowest ranges, zero count acts as one
    settle_block();
    load_reg(CFG_ACCEL_RANGE, 0);
    load_reg(CFG_RATE_RANGE, 0);
    load_reg(CFG_CALIB_COUNT, 0);
    push_sample(make_sample(ACT_CAL_START));
    push_sample(flat_sample(ACT_CAL_SAMPLE, 16'sh0000, 16'sh0000, 16'sh8000));
    push_sample(flat_sample(ACT_CONVERT, 16'sh7fff, 16'sh7fff, 16'sh7fff));

    // bias load and convert inside a run, then the count is lowered mid-run
    settle_block();
    load_reg(CFG_ACCEL_RANGE, 2);
    load_reg(CFG_RATE_RANGE, 2);
    load_reg(CFG_CALIB_COUNT, 4096);
    push_sample(make_sample(ACT_CAL_START));
    push_sample(make_sample(ACT_CAL_SAMPLE));
    push_sample(make_sample(ACT_SET_BIAS));
    push_sample(make_sample(ACT_CONVERT));
    push_sample(make_sample(ACT_CAL_SAMPLE));
    settle_block();
    load_reg(CFG_CALIB_COUNT, 2);
    push_sample(make_sample(ACT_CAL_SAMPLE));
    push_sample(make_sample(ACT_CONVERT));

    // count above the maximum keeps the run open, then a lowered count closes it
    settle_block();
    load_reg(CFG_RATE_RANGE, 3);
    load_reg(CFG_CALIB_COUNT, 8191);
    push_sample(make_sample(ACT_CAL_START));
    for (int k = 0; k < LONG_RUN; k++) begin
      item_buf = make_sample(ACT_CAL_SAMPLE);
      if ($urandom_range(0, 3) != 0)
        for (int i = 0; i < NUM_LANES; i++) item_buf.rate[i] = 16'sh7fff;
      push_sample(item_buf);
    end
    push_sample(make_sample(ACT_CONVERT));
    settle_block();
    load_reg(CFG_CALIB_COUNT, 1);
    push_sample(make_sample(ACT_CAL_SAMPLE));
    push_sample(make_sample(ACT_CONVERT));

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_block();
      idle_on = (p < RAND_PHASES - QUIET_PHASES);
      count_cfg = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 12);
      run_len   = (count_cfg == 0) ? 1 : count_cfg;
      load_reg(CFG_ACCEL_RANGE, $urandom_range(0, 3));
      load_reg(CFG_RATE_RANGE, $urandom_range(0, 3));
      load_reg(CFG_CALIB_COUNT, count_cfg);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: begin
            push_sample(make_sample(ACT_CAL_START));
            for (int k = 0; k < run_len; k++) begin
              while ($urandom_range(0, 3) == 0) push_sample(make_sample(ACT_CONVERT));
              if ($urandom_range(0, 19) == 0) push_sample(make_sample(ACT_SET_BIAS));
              push_sample(make_sample(ACT_CAL_SAMPLE));
            end
          end
          5, 6, 7: push_sample(make_sample(ACT_CONVERT));
          8:       push_sample(make_sample(action_t'($urandom_range(0, 3))));
          default: push_sample(make_sample(ACT_SET_BIAS));
        endcase
      end
    end

    settle_block();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("imu_scale_bias_calibrate_top_tb: done, clean");
    end else begin
      $display("imu_scale_bias_calibrate_top_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/isbc_pkg.sv
hw/rtl/isbc_if.sv
hw/rtl/isbc_lane.sv
hw/rtl/imu_scale_bias_calibrate_top.sv
tb/imu_scale_bias_calibrate_top_tb.sv
